// ===== hdl/rgbfx_pkg.sv =====
package rgbfx_pkg;

  localparam int unsigned FRAME_MAX  = 8;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0] RED_ONCE_LEVEL = 8'd32;
  localparam logic [7:0] HUE_REGION     = 8'd43;
  localparam logic [7:0] TRI_HALF       = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED    = 3'd0,
    REG_EFFECT     = 3'd1,
    REG_MAX_BRIGHT = 3'd2,
    REG_UPD_TICKS  = 3'd3,
    REG_PHASE_STEP = 3'd4,
    REG_BOOT_RETRY = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    FX_STATIC       = 2'd0,
    FX_SOLID_BREATH = 2'd1,
    FX_RAINBOW      = 2'd2,
    FX_BREATH_FLOW  = 2'd3
  } effect_t;

  typedef struct packed {
    logic       enabled;
    effect_t    effect;
    logic [7:0] max_brightness;
  } fx_cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic logic [7:0] tri_level(input logic [7:0] p);
    logic [7:0] q;
    q = (p < TRI_HALF) ? p : (8'd255 - p);
    return {q[6:0], 1'b0};
  endfunction

endpackage

// ===== hdl/rgbfx_pixel.sv =====
module rgbfx_pixel
  import rgbfx_pkg::*;
(
  input  logic             dim_red,
  input  fx_cfg_t          cfg,
  input  logic [7:0]       phase,
  input  logic [IDX_W-1:0] idx,
  output rgb_t             pix
);

  logic [7:0]  tri_v;
  logic [7:0]  hue;
  logic [7:0]  bright;
  logic [2:0]  region;
  logic [7:0]  base;
  logic [7:0]  rem;
  logic [10:0] step_w;
  logic [7:0]  step;
  logic [15:0] up_p;
  logic [15:0] down_p;
  logic [7:0]  up;
  logic [7:0]  down;
  rgb_t        wheel;

  assign tri_v = tri_level(phase);

  always_comb begin
    if (cfg.effect == FX_RAINBOW) begin
      hue    = phase + 8'(idx) * 8'd7;
      bright = cfg.max_brightness;
    end else begin
      hue    = {phase[6:0], 1'b0} + 8'(idx) * 8'd5;
      bright = tri_v;
    end
  end

  always_comb begin
    if (hue >= 8'(5 * HUE_REGION)) begin
      region = 3'd5;
    end else if (hue >= 8'(4 * HUE_REGION)) begin
      region = 3'd4;
    end else if (hue >= 8'(3 * HUE_REGION)) begin
      region = 3'd3;
    end else if (hue >= 8'(2 * HUE_REGION)) begin
      region = 3'd2;
    end else if (hue >= HUE_REGION) begin
      region = 3'd1;
    end else begin
      region = 3'd0;
    end
  end

  assign base   = 8'(region) * HUE_REGION;
  assign rem    = hue - base;
  assign step_w = 11'(rem) * 11'd6;
  assign step   = step_w[7:0];
  assign up_p   = 16'(step) * 16'(bright);
  assign down_p = 16'(8'd255 - step) * 16'(bright);
  assign up     = up_p[15:8];
  assign down   = down_p[15:8];

  always_comb begin
    case (region)
      3'd0:    wheel = '{red: bright, green: up,     blue: 8'd0};
      3'd1:    wheel = '{red: down,   green: bright, blue: 8'd0};
      3'd2:    wheel = '{red: 8'd0,   green: bright, blue: up};
      3'd3:    wheel = '{red: 8'd0,   green: down,   blue: bright};
      3'd4:    wheel = '{red: up,     green: 8'd0,   blue: bright};
      default: wheel = '{red: bright, green: 8'd0,   blue: down};
    endcase
  end

  always_comb begin
    pix = '0;
    if (dim_red) begin
      pix.red = RED_ONCE_LEVEL;
    end else if (cfg.enabled) begin
      case (cfg.effect)
        FX_STATIC: begin
          pix.green = cfg.max_brightness;
          pix.blue  = cfg.max_brightness;
        end
        FX_SOLID_BREATH: begin
          pix.green = tri_v;
          pix.blue  = tri_v;
        end
        default: pix = wheel;
      endcase
    end
  end

endmodule

// ===== hdl/rgb_led_effect_frame_generator_unit.sv =====
// Channel  Dir  Beat                  Payload
// in_      in   one command           tuser: cmd; tdata: tick_now
// out_     out  one pixel             tdata: led_index, red, green, blue; tlast: last pixel
// cfg_     in   one register write    cfg_index selects, cfg_wdata holds the value
//
// A tick is decided in the cycle it is accepted; one that yields no frame leaves in_tready high.
// A frame holds min(LED_COUNT, 8) pixels, sent at one pixel per cycle while out_tready
// is high, set by the pixel sequencer; a command with a frame is accepted first, and the
// next command is taken the cycle after the last pixel enters the output register.
// Reset is synchronous, active low, and loads the register reset values.
// out_tready low holds a valid output register and the sequencer; no beat is lost.
module rgb_led_effect_frame_generator_unit
  import rgbfx_pkg::*;
#(
  parameter int unsigned LED_COUNT = FRAME_MAX
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // tick_now
  input  logic                  in_tuser,   // cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // led_index, red, green, blue, zero pad
  output logic                  out_tlast,  // last_pixel
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned FRAME_LEN = (LED_COUNT > FRAME_MAX) ? FRAME_MAX :
                                      ((LED_COUNT < 1) ? 1 : LED_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  fx_cfg_t          fx_cfg_r;
  logic [15:0]      upd_ticks_r;
  logic [7:0]       phase_step_r;

  logic [7:0]       phase_r;
  logic [15:0]      last_tick_r;
  logic [15:0]      retry_left_r;

  logic             job_valid_r;
  logic             job_red_r;
  logic [7:0]       job_phase_r;
  logic [IDX_W-1:0] pix_idx_r;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  rgb_t             out_pix_r;
  logic             out_last_r;

  logic             in_acc;
  logic [15:0]      elapsed;
  logic             upd;
  logic             retry;
  logic             emit;
  logic [7:0]       phase_nxt;
  logic             load;
  logic             pix_last;
  rgb_t             pix;

  assign in_tready = !job_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign elapsed   = in_tdata - last_tick_r;
  assign upd       = !in_tuser && (elapsed >= upd_ticks_r);
  assign retry     = (retry_left_r != 16'd0);
  assign phase_nxt = phase_r + phase_step_r;
  assign emit      = in_tuser ||
                     (upd && ((fx_cfg_r.enabled && fx_cfg_r.effect != FX_STATIC) || retry));
  assign load      = job_valid_r && (!out_valid_r || out_tready);
  assign pix_last  = (pix_idx_r == LAST_IDX);

  rgbfx_pixel u_pixel (
    .dim_red  (job_red_r),
    .cfg      (fx_cfg_r),
    .phase    (job_phase_r),
    .idx      (pix_idx_r),
    .pix      (pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_cfg_r     <= '{enabled: 1'b0, effect: FX_BREATH_FLOW, max_brightness: 8'd255};
      upd_ticks_r  <= 16'd32;
      phase_step_r <= 8'd2;
      phase_r      <= '0;
      last_tick_r  <= '0;
      retry_left_r <= 16'd256;
      job_valid_r  <= 1'b0;
      job_red_r    <= 1'b0;
      job_phase_r  <= '0;
      pix_idx_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLED:    fx_cfg_r.enabled        <= cfg_wdata[0];
          REG_EFFECT:     fx_cfg_r.effect         <= effect_t'(cfg_wdata[1:0]);
          REG_MAX_BRIGHT: fx_cfg_r.max_brightness <= cfg_wdata[7:0];
          REG_UPD_TICKS:  upd_ticks_r             <= cfg_wdata;
          REG_PHASE_STEP: phase_step_r            <= cfg_wdata[7:0];
          REG_BOOT_RETRY: retry_left_r            <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_acc) begin
        if (upd) begin
          last_tick_r <= in_tdata;
          phase_r     <= phase_nxt;
          if (retry) begin
            retry_left_r <= retry_left_r - 16'd1;
          end
        end
        if (emit) begin
          job_valid_r <= 1'b1;
          job_red_r   <= in_tuser;
          job_phase_r <= phase_nxt;
          pix_idx_r   <= '0;
        end
      end

      if (load) begin
        pix_idx_r <= pix_idx_r + IDX_W'(1);
        if (pix_last) begin
          job_valid_r <= 1'b0;
        end
      end

      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_idx_r  <= pix_idx_r;
      out_pix_r  <= pix;
      out_last_r <= pix_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_pix_r.blue, out_pix_r.green, out_pix_r.red, out_idx_r};

  a_red_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser |=> job_valid_r && job_red_r && (pix_idx_r == '0))
    else $error("red request did not start a frame");

  a_retry_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cfg_we) |-> retry_left_r <= $past(retry_left_r))
    else $error("boot retry count rose without a write");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_idx_r == LAST_IDX)
    else $error("last pixel flag on wrong index");

endmodule
